// ----- rtl/psched_pkg.sv -----
// ----------------------------------------------------------------------------
// psched_pkg
// Types and constants shared by the periodic slot scheduler modules.
// ----------------------------------------------------------------------------
package psched_pkg;

  localparam int TICK_W      = 32;
  localparam int TASK_W      = 16;
  localparam int MAX_RESULTS = 8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REG   = 2'd1,
    CMD_UNREG = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_REG       = 3'd1,
    KIND_REG_FAIL  = 3'd2,
    KIND_UNREG     = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] due;
  } slot_entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        slot;
    logic [TASK_W-1:0] task_id;
  } result_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/psched_ram.sv -----
// ----------------------------------------------------------------------------
// psched_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psched_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/psched_div.sv -----
// ----------------------------------------------------------------------------
// psched_div
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module psched_div
  import psched_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [TICK_W-1:0] divisor,
  output logic              done,
  output logic [TICK_W-1:0] remainder
);

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [TICK_W-1:0] quo;
  logic [TICK_W-1:0] dvs;
  logic [TICK_W:0]   trial;
  logic              fits;

  assign trial = {remainder, quo[TICK_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TICK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[TICK_W-2:0], 1'b0};
      if (fits) begin
        remainder <= TICK_W'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[TICK_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/periodic_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_slot_scheduler
// Slot table of periodic tasks driven by a wrapping 32-bit tick counter.
// ----------------------------------------------------------------------------
// One word is taken at a time. Slot data (task, period, due tick) live in a
// single RAM that is read one slot at a time, a read state then a check state
// per slot; used flags are flip-flops cleared at reset, so no clearing pass is
// needed. A tick or an unregister word walks the slots; a register word sets
// the due tick from phase mod period, found by the 32-step remainder unit.
// A stalled output holds the walk. Fired results of a tick go out in slot order,
// at most eight, with tlast on the final one; a tick with nothing due sends
// nothing.
module periodic_slot_scheduler
  import psched_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // task_id[15:0], period[47:16], phase[79:48]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // slot_index[2:0], fired_task[18:3],
                                 // current_tick[50:19], zero
  output logic [2:0]  m_tuser,   // result_kind[2:0]
  output logic        m_tlast
);

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam int FC_W = $clog2(MAX_RESULTS + 1);

  state_t state, state_next;

  logic [TICK_W-1:0] tick;
  logic [SLOTS-1:0]  used;
  logic [IW-1:0]     idx;
  logic [FC_W-1:0]   fired_cnt;
  cmd_t              cmd;
  logic [TASK_W-1:0] id_r;
  logic [TICK_W-1:0] per_r;
  result_t           pend;
  logic              pend_valid;

  logic              out_valid;
  result_t           out_res;
  logic [TICK_W-1:0] out_tick;
  logic              out_last;

  logic              accept;
  logic              out_free;
  cmd_t              in_cmd;
  logic [TASK_W-1:0] in_id;
  logic [TICK_W-1:0] in_per;
  logic [TICK_W-1:0] in_ph;
  logic [IW-1:0]     free_idx;
  logic              free_any;
  logic              reg_ok;

  slot_entry_t       rd_ent;
  slot_entry_t       wr_ent;
  logic              rd_en;
  logic              wr_en;
  logic              push;
  logic              push_last;
  logic              hit_tick;
  logic              hit_unreg;
  logic              can_emit;
  logic              stall;
  div_ctl_t          div_ctl;
  logic [TICK_W-1:0] rem;

  assign in_cmd = cmd_t'(s_tuser);
  assign in_id  = s_tdata[15:0];
  assign in_per = s_tdata[47:16];
  assign in_ph  = s_tdata[79:48];

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign free_any = ~&used;
  assign reg_ok   = (in_id != '0) && (in_per != '0) && free_any;

  assign hit_tick  = used[idx] && (rd_ent.due == tick);
  assign hit_unreg = used[idx] && (rd_ent.task_id == id_r);
  assign can_emit  = fired_cnt < FC_W'(MAX_RESULTS);
  assign stall     = (cmd == CMD_TICK) && hit_tick && can_emit && pend_valid && !out_free;

  assign div_ctl.start = accept && (in_cmd == CMD_REG) && reg_ok;

  psched_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_ctl.start),
    .dividend  (in_ph),
    .divisor   (in_per),
    .done      (div_ctl.done),
    .remainder (rem)
  );

  psched_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_ent)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_TICK, CMD_UNREG: state_next = S_READ;
            CMD_REG:             state_next = reg_ok ? S_DIV : S_FLUSH;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (cmd == CMD_UNREG) begin
          if (hit_unreg || idx == LAST_IDX) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_READ;
          end
        end else if (!stall) begin
          state_next = (idx == LAST_IDX) ? S_FLUSH : S_READ;
        end
      end
      S_DIV: begin
        if (div_ctl.done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_ent    = rd_ent;
    push      = 1'b0;
    push_last = 1'b0;
    case (state)
      S_READ: rd_en = 1'b1;
      S_CHECK: begin
        if (cmd == CMD_TICK && hit_tick && !stall) begin
          wr_en      = 1'b1;
          wr_ent.due = rd_ent.due + rd_ent.period;
          push       = can_emit && pend_valid;
        end
      end
      S_DIV: begin
        wr_en          = div_ctl.done;
        wr_ent.task_id = id_r;
        wr_ent.period  = per_r;
        wr_ent.due     = tick + rem + 1'b1;
      end
      S_FLUSH: begin
        push      = pend_valid && out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick       <= '0;
      used       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      fired_cnt  <= '0;
    end else begin
      state     <= state_next;
      out_valid <= push || (out_valid && !m_tready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            fired_cnt <= '0;
            if (in_cmd == CMD_TICK) begin
              tick <= tick + 1'b1;
            end
            if (in_cmd == CMD_REG && !reg_ok) begin
              pend_valid <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (cmd == CMD_UNREG) begin
            if (hit_unreg) begin
              used[idx]  <= 1'b0;
              pend_valid <= 1'b1;
            end else if (idx == LAST_IDX) begin
              pend_valid <= 1'b1;
            end
          end else if (hit_tick && !stall && can_emit) begin
            pend_valid <= 1'b1;
            fired_cnt  <= fired_cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (div_ctl.done) begin
            used[idx]  <= 1'b1;
            pend_valid <= 1'b1;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd   <= in_cmd;
          id_r  <= in_id;
          per_r <= in_per;
          idx   <= (in_cmd == CMD_REG) ? free_idx : '0;
          pend  <= '{kind: KIND_REG_FAIL, slot: 3'd0, task_id: '0};
        end
      end
      S_CHECK: begin
        if (cmd == CMD_UNREG) begin
          if (hit_unreg) begin
            pend <= '{kind: KIND_UNREG, slot: 3'(idx), task_id: id_r};
          end else if (idx == LAST_IDX) begin
            pend <= '{kind: KIND_NOT_FOUND, slot: 3'd0, task_id: '0};
          end else begin
            idx <= idx + 1'b1;
          end
        end else if (!stall) begin
          if (hit_tick && can_emit) begin
            pend <= '{kind: KIND_FIRED, slot: 3'(idx), task_id: rd_ent.task_id};
          end
          if (idx != LAST_IDX) begin
            idx <= idx + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_ctl.done) begin
          pend <= '{kind: KIND_REG, slot: 3'(idx), task_id: id_r};
        end
      end
      default: ;
    endcase
    if (push) begin
      out_res  <= pend;
      out_tick <= tick;
      out_last <= push_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_tick, out_res.task_id, out_res.slot};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_last;

endmodule

// ----- tb/tb_periodic_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_periodic_slot_scheduler
// Self-checking bench for the periodic slot scheduler. A directed sequence
// covers bad and full registers, duplicate ids, unregister misses, the unused
// command and a tick that fires every slot. Random commands follow in phases
// with different sender and receiver idling, plus one long output hold-off.
// Every accepted command updates a local copy of the slot table; the words
// it predicts are compared in order with the words the block sends.
// ----------------------------------------------------------------------------
module tb_periodic_slot_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import psched_pkg::*;

  localparam int NSLOT = 8;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] id;
    logic [31:0] period;
    logic [31:0] phase;
  } sched_cmd_t;

  typedef struct {
    kind_t       kind;
    logic [2:0]  slot;
    logic [15:0] task_id;
    logic [31:0] tick;
    logic        last;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  periodic_slot_scheduler #(.SLOTS(NSLOT)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sched_cmd_t  cmd_queue[$];
  sched_res_t  sched_results[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic        in_taken = 1'b0;

  // shadow of the slot table
  logic [31:0] ticks_now = '0;
  logic        slot_busy  [NSLOT] = '{default: 1'b0};
  logic [31:0] slot_per   [NSLOT] = '{default: '0};
  logic [31:0] slot_due   [NSLOT] = '{default: '0};
  logic [15:0] slot_owner [NSLOT] = '{default: '0};

  task automatic sched_apply(input cmd_t cmd, input logic [15:0] id,
                             input logic [31:0] per, input logic [31:0] ph);
    sched_res_t r;
    sched_res_t out_q[$];
    int hit;
    hit = -1;
    case (cmd)
      CMD_TICK: begin
        ticks_now = ticks_now + 32'd1;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_busy[i] && slot_due[i] == ticks_now) begin
            if (out_q.size() < MAX_RESULTS) begin
              r = '{KIND_FIRED, 3'(i), slot_owner[i], ticks_now, 1'b0};
              out_q.push_back(r);
            end
            slot_due[i] = slot_due[i] + slot_per[i];
          end
        end
      end
      CMD_REG: begin
        if (id != 0 && per != 0) begin
          for (int i = 0; i < NSLOT; i++)
            if (hit < 0 && !slot_busy[i]) hit = i;
        end
        if (hit >= 0) begin
          slot_busy[hit]  = 1'b1;
          slot_per[hit]   = per;
          slot_due[hit]   = ticks_now + (ph % per) + 32'd1;
          slot_owner[hit] = id;
          r = '{KIND_REG, 3'(hit), id, ticks_now, 1'b0};
        end else begin
          r = '{KIND_REG_FAIL, 3'd0, 16'd0, ticks_now, 1'b0};
        end
        out_q.push_back(r);
      end
      CMD_UNREG: begin
        for (int i = 0; i < NSLOT; i++)
          if (hit < 0 && slot_busy[i] && slot_owner[i] == id) hit = i;
        if (hit >= 0) begin
          slot_busy[hit] = 1'b0;
          r = '{KIND_UNREG, 3'(hit), id, ticks_now, 1'b0};
        end else begin
          r = '{KIND_NOT_FOUND, 3'd0, 16'd0, ticks_now, 1'b0};
        end
        out_q.push_back(r);
      end
      default: ;
    endcase
    if (out_q.size() > 0) out_q[out_q.size()-1].last = 1'b1;
    foreach (out_q[k]) sched_results.push_back(out_q[k]);
  endtask

  // sender: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin : drive
    sched_cmd_t c;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {c.phase, c.period, c.id};
          s_tuser  <= c.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : mon
    sched_res_t  e;
    logic [55:0] want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sched_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: data=%h kind=%0d last=%b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          e = sched_results.pop_front();
          want = {5'b00000, e.tick, e.task_id, e.slot};
          if (m_tdata !== want || m_tuser !== e.kind || m_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp kind=%0d slot=%0d task=%h tick=%h last=%b",
                       e.kind, e.slot, e.task_id, e.tick, e.last,
                       " | got data=%h kind=%0d last=%b", m_tdata, m_tuser, m_tlast);
          end
        end
      end
      in_taken = s_tvalid && s_tready;
      if (in_taken) sched_apply(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[47:16], s_tdata[79:48]);
    end
  end

  task automatic add_cmd(input cmd_t cmd, input logic [15:0] id,
                         input logic [31:0] per, input logic [31:0] ph);
    sched_cmd_t c;
    c = '{cmd, id, per, ph};
    cmd_queue.push_back(c);
  endtask

  task automatic add_random(input int count);
    sched_cmd_t c;
    int n;
    int r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      c.cmd = (r < 50) ? CMD_TICK : (r < 75) ? CMD_REG : (r < 96) ? CMD_UNREG : CMD_NONE;
      r = $urandom_range(19);
      c.id = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 10));
      r = $urandom_range(19);
      if (r == 0)       c.period = 32'd0;
      else if (r <= 8)  c.period = $urandom_range(1, 4);
      else if (r <= 15) c.period = $urandom_range(5, 40);
      else              c.period = $urandom;
      c.phase = $urandom_range(1) ? $urandom : $urandom_range(63);
      cmd_queue.push_back(c);
      if (c.cmd != CMD_NONE) n++;
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || s_tvalid || sched_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed
    add_cmd(CMD_TICK,  16'd0,      32'd0,          32'd0);
    add_cmd(CMD_REG,   16'd0,      32'd5,          32'd0);
    add_cmd(CMD_REG,   16'd7,      32'd0,          32'd3);
    add_cmd(CMD_UNREG, 16'd0,      32'd0,          32'd0);
    add_cmd(CMD_NONE,  16'hFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF);
    add_cmd(CMD_REG,   16'hFFFF,   32'd1,          32'd0);
    add_cmd(CMD_REG,   16'd1,      32'hFFFFFFFF,   32'hFFFFFFFF);
    add_cmd(CMD_REG,   16'd2,      32'd1,          32'hFFFFFFFF);
    add_cmd(CMD_REG,   16'd5,      32'd1,          32'd0);
    add_cmd(CMD_REG,   16'd5,      32'd1,          32'd0);
    add_cmd(CMD_REG,   16'd9,      32'd1,          32'd0);
    add_cmd(CMD_REG,   16'd10,     32'd1,          32'd0);
    add_cmd(CMD_REG,   16'd11,     32'd3,          32'd3);
    add_cmd(CMD_REG,   16'd12,     32'd1,          32'd0);
    add_cmd(CMD_TICK,  16'd0,      32'd0,          32'd0);
    add_cmd(CMD_TICK,  16'h1234,   32'h5555AAAA,   32'hAAAA5555);
    add_cmd(CMD_UNREG, 16'd5,      32'd0,          32'd0);
    add_cmd(CMD_UNREG, 16'd5,      32'd0,          32'd0);
    add_cmd(CMD_UNREG, 16'd5,      32'd0,          32'd0);
    add_cmd(CMD_REG,   16'h8000,   32'h80000000,   32'h7FFFFFFF);
    add_cmd(CMD_REG,   16'd3,      32'd3,          32'hFFFFFFFE);
    add_cmd(CMD_UNREG, 16'h1234,   32'd0,          32'd0);
    add_cmd(CMD_TICK,  16'd0,      32'd0,          32'd0);
    add_cmd(CMD_TICK,  16'd0,      32'd0,          32'd0);
    add_cmd(CMD_TICK,  16'd0,      32'd0,          32'd0);
    wait_drained();

    // random phases: {sender idle %, receiver stall %}
    send_idle_pct = 0;  stall_pct = 0;  add_random(86); wait_drained();
    send_idle_pct = 60; stall_pct = 0;  add_random(86); wait_drained();
    send_idle_pct = 0;  stall_pct = 60; add_random(86); wait_drained();
    send_idle_pct = 30; stall_pct = 30; add_random(86); wait_drained();

    // output held off while the sender keeps offering words
    send_idle_pct = 0;  stall_pct = 0;  add_random(86);
    hold_left = 400;
    wait_drained();

    repeat (100) @(posedge clk);
    if (errors == 0 && sched_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
